// File: rtl/core/f9sf_pkg.sv
// ----------------------------------------------------------------------------
// f9sf_pkg
// Shared widths, frame constants and the tap coefficient table of the framer.
// ----------------------------------------------------------------------------
package f9sf_pkg;

    localparam int TAPS     = 9;
    localparam int SLOT_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W    = $clog2(TAPS + 1);
    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 8;
    localparam int PROD_W   = SAMPLE_W + 1 + COEF_W;
    localparam int ACC_W    = 16;
    localparam int BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] FRAME_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] RAW_HEADER = 8'h40;

    // coefficient for the sample j items back, zero past the ninth tap
    function automatic logic signed [COEF_W-1:0] coef_at(input int unsigned j);
        logic signed [COEF_W-1:0] c;
        case (j)
            1:       c = -8'sd6;
            3:       c = 8'sd70;
            4:       c = 8'sd127;
            5:       c = 8'sd70;
            7:       c = -8'sd6;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/fir9_sample_framer.sv
// ----------------------------------------------------------------------------
// fir9_sample_framer
// 9-tap FIR (or raw pass-through) over converter samples, packed into a marked three-byte frame.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: sample_valid / sample_stall, one 8-bit reading per transfer.
//   frame channel: frame_valid / frame_stall, frame_byte0..2 per transfer.
//   cfg channel: cfg_valid / cfg_ready (always ready), cfg_data = filter_enable.
//   Write cfg only while the block is idle.
// Timing:
//   filter mode: the delay line sits in a small RAM with one read port; one tap
//   is read and multiply-accumulated per cycle, and the finished sum is then
//   moved into the frame register.
//   raw mode: the delay line is untouched; the sample goes to the frame register.
//   A new sample is taken once the previous item has been moved into the frame
//   register, even if that frame is still waiting for the receiver.
// Reset:
//   delay line reads as zero (per-entry valid bits cleared), write slot zero,
//   filter mode on, no frame pending.
// Stall:
//   a stalled frame holds; the next finished item waits for it to drain.
// ----------------------------------------------------------------------------
module fir9_sample_framer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [f9sf_pkg::SAMPLE_W-1:0]   sample,
    output logic                            frame_valid,
    input  logic                            frame_stall,
    output logic [f9sf_pkg::BYTE_W-1:0]     frame_byte0,
    output logic [f9sf_pkg::BYTE_W-1:0]     frame_byte1,
    output logic [f9sf_pkg::BYTE_W-1:0]     frame_byte2,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data
);

    import f9sf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic                      filter_enable_reg;
    logic [SLOT_W-1:0]         wslot_reg, wslot_next;
    logic [SLOT_W-1:0]         rslot_reg, rslot_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic                      pend_reg, pend_next;
    logic                      pend_ok_reg, pend_ok_next;
    logic signed [COEF_W-1:0]  pend_coef_reg, pend_coef_next;
    logic [TAPS-1:0]           valid_reg, valid_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic                      raw_reg, raw_next;
    logic [SAMPLE_W-1:0]       sample_reg, sample_next;
    logic                      frame_valid_reg, frame_valid_next;
    logic [BYTE_W-1:0]         byte0_reg, byte0_next;
    logic [BYTE_W-1:0]         byte1_reg, byte1_next;
    logic [BYTE_W-1:0]         byte2_reg, byte2_next;

    logic                      sample_xfer;
    logic                      ram_wr_en;
    logic [SAMPLE_W-1:0]       ram_rd_data;
    logic [SAMPLE_W-1:0]       mul_a;
    logic signed [COEF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod;

    f9sf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wslot_reg),
        .wr_data (sample),
        .rd_addr (rslot_reg),
        .rd_data (ram_rd_data)
    );

    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_xfer  = sample_valid && (state_reg == ST_IDLE);
    assign ram_wr_en    = sample_xfer && filter_enable_reg;
    assign cfg_ready    = 1'b1;

    // one shared multiplier: newest sample at transfer, RAM data afterwards
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            mul_a = sample;
            mul_b = coef_at(0);
        end
        else
        begin
            mul_a = pend_ok_reg ? ram_rd_data : '0;
            mul_b = pend_coef_reg;
        end
    end

    assign prod = $signed({1'b0, mul_a}) * mul_b;

    always_comb
    begin
        state_next       = state_reg;
        wslot_next       = wslot_reg;
        rslot_next       = rslot_reg;
        issue_next       = issue_reg;
        pend_next        = 1'b0;
        pend_ok_next     = pend_ok_reg;
        pend_coef_next   = pend_coef_reg;
        valid_next       = valid_reg;
        acc_next         = acc_reg;
        raw_next         = raw_reg;
        sample_next      = sample_reg;
        frame_valid_next = frame_valid_reg && frame_stall;
        byte0_next       = byte0_reg;
        byte1_next       = byte1_reg;
        byte2_next       = byte2_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    sample_next = sample;
                    raw_next    = !filter_enable_reg;
                    if (filter_enable_reg)
                    begin
                        valid_next[wslot_reg] = 1'b1;
                        acc_next   = ACC_W'(prod);
                        issue_next = CNT_W'(1);
                        rslot_next = (wslot_reg == '0) ? SLOT_W'(TAPS - 1)
                                                       : wslot_reg - SLOT_W'(1);
                        wslot_next = (wslot_reg == SLOT_W'(TAPS - 1)) ? '0
                                                                      : wslot_reg + SLOT_W'(1);
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_RUN:
            begin
                // read for tap issue_reg, accumulate it in the next cycle
                if (issue_reg != CNT_W'(TAPS))
                begin
                    pend_next      = 1'b1;
                    pend_ok_next   = valid_reg[rslot_reg];
                    pend_coef_next = coef_at(32'(issue_reg));
                    issue_next     = issue_reg + CNT_W'(1);
                    rslot_next     = (rslot_reg == '0) ? SLOT_W'(TAPS - 1)
                                                       : rslot_reg - SLOT_W'(1);
                end
                if (pend_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod);
                end
                if ((issue_reg == CNT_W'(TAPS)) && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!frame_valid_reg || !frame_stall)
                begin
                    frame_valid_next = 1'b1;
                    if (raw_reg)
                    begin
                        byte0_next = RAW_HEADER;
                        byte1_next = FRAME_MARK | {4'b0, sample_reg[7:4]};
                        byte2_next = FRAME_MARK | {4'b0, sample_reg[3:0]};
                    end
                    else
                    begin
                        byte0_next = {2'b0, acc_reg[15:10]};
                        byte1_next = FRAME_MARK | {3'b0, acc_reg[9:5]};
                        byte2_next = FRAME_MARK | {3'b0, acc_reg[4:0]};
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            filter_enable_reg <= 1'b1;
            wslot_reg         <= '0;
            rslot_reg         <= '0;
            issue_reg         <= '0;
            pend_reg          <= 1'b0;
            valid_reg         <= '0;
            frame_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wslot_reg       <= wslot_next;
            rslot_reg       <= rslot_next;
            issue_reg       <= issue_next;
            pend_reg        <= pend_next;
            valid_reg       <= valid_next;
            frame_valid_reg <= frame_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                filter_enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ok_reg   <= pend_ok_next;
        pend_coef_reg <= pend_coef_next;
        acc_reg       <= acc_next;
        raw_reg       <= raw_next;
        sample_reg    <= sample_next;
        byte0_reg     <= byte0_next;
        byte1_reg     <= byte1_next;
        byte2_reg     <= byte2_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame_byte0 = byte0_reg;
    assign frame_byte1 = byte1_reg;
    assign frame_byte2 = byte2_reg;

endmodule

// File: rtl/core/f9sf_ram.sv
// ----------------------------------------------------------------------------
// f9sf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module f9sf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
